// ===== rtl/outstanding_tag_tracker_top_macros.svh =====
// Assertion macros for the outstanding tag tracker.
// Included by outstanding_tag_tracker_top.sv; no other dependencies.
`ifndef OUTSTANDING_TAG_TRACKER_TOP_MACROS_SVH
`define OUTSTANDING_TAG_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OOT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define OOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/oot_pkg.sv =====
// Package for the outstanding tag tracker: payload structs, codes and state type.
// Used by outstanding_tag_tracker_top.sv; has no dependencies.
package oot_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int MAX_RESULTS         = 16;
   localparam int N_W                 = $clog2(MAX_RESULTS + 1);

   localparam logic [31:0] TIMEOUT_RESET = 32'd5000000;
   localparam logic [31:0] GUARD_RESET   = 32'd10000;

   // Configuration register indexes.
   localparam logic [0:0] CSR_TIMEOUT = 1'b0;
   localparam logic [0:0] CSR_GUARD   = 1'b1;

   // Command codes.
   localparam logic [1:0] CMD_SEND  = 2'd0;
   localparam logic [1:0] CMD_REPLY = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_SENT    = 3'd0;
   localparam logic [2:0] KIND_MATCH   = 3'd1;
   localparam logic [2:0] KIND_DISCARD = 3'd2;
   localparam logic [2:0] KIND_TIMEOUT = 3'd3;
   localparam logic [2:0] KIND_FULL    = 3'd4;
   localparam logic [2:0] KIND_NONE    = 3'd5;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] now_ticks;
      logic [15:0] reply_tag;
      logic [7:0]  requester_id;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] tag;
      logic [7:0]  owner;
      logic [31:0] timer_delay;
      logic        timer_update;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [31:0] sent_time;
      logic [7:0]  owner;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEND,
      ST_SRCH_RD,
      ST_SRCH_EV,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_TICK_RD,
      ST_TICK_EV,
      ST_TICK_CALC,
      ST_FIN_RD,
      ST_FIN_EV,
      ST_FIN_OUT
   } state_type;

endpackage

// ===== rtl/outstanding_tag_tracker_top.sv =====
// Outstanding tag tracker: in-order table of in-flight requests with timeout.
// Depends on oot_pkg and outstanding_tag_tracker_top_macros.svh.
//
// This block keeps up to TABLE_DEPTH in-flight requests in send order. A send
// transaction assigns the next 16-bit tag and appends it with its send time and
// requester id; a reply transaction searches from the oldest entry and removes
// the first entry with a matching tag; a tick transaction removes expired
// entries from the front (at most 16 per tick) and reports each as a timeout.
// The final result of every transaction carries the reload delay for the
// oldest remaining entry. The table lives in a single-port-read, single-port-
// write memory addressed as a ring (head pointer plus count), and one shared
// remaining-time unit (a wrapping subtract, a signed subtract and a compare)
// evaluates entries one at a time under a small sequencer. The block takes one
// transaction at a time and is not ready while it works. A send writes its
// entry unless the table is full; a reply reads and compares each entry
// searched, then reads and writes each younger entry moved up when a middle
// entry is removed; a tick reads, times and compares each entry examined
// (every expired entry, plus the first live entry when the walk reaches one).
// Every transaction ends by reading the head entry for the final delay. A
// result still in the output register can stall the tick walk and the final
// result. Memory reads are registered; each evaluated entry costs a read, a
// registered elapsed-time stage and a compare. A finished result sits in an
// output register, so the next transaction may be accepted while it waits.
// The table is not cleared at reset; only entries below the count are read.
`include "outstanding_tag_tracker_top_macros.svh"

module outstanding_tag_tracker_top #(
   parameter int TABLE_DEPTH = oot_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  oot_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output oot_pkg::rsp_payload_type rsp_payload,
   input  logic                    csr_we,
   input  logic [0:0]              csr_index,
   input  logic [31:0]             csr_wdata
);
   import oot_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Ring index: base plus offset, both below the depth, folded once.
   function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IDX_W+1)'(TABLE_DEPTH)) begin
         sum = sum - (IDX_W+1)'(TABLE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Control state.
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic [15:0]      base_ff, base_in;
   logic [31:0]      timeout_ff, guard_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   req_payload_type  req_ff;
   rsp_payload_type  rsp_payload_ff, emit_payload;
   logic [2:0]       fin_kind_ff, fin_kind_in;
   logic [15:0]      fin_tag_ff, fin_tag_in;
   logic [7:0]       fin_owner_ff, fin_owner_in;
   logic             fin_upd_ff, fin_upd_in;
   logic [31:0]      elapsed_ff;

   // Table memory.
   entry_type        entry_mem_ff [TABLE_DEPTH];
   entry_type        rd_data_ff, wr_data;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             rd_en, wr_en, elapsed_en;

   logic             emit, req_take;
   logic             slot_free, tag_hit, expired, pos_more, shift_more, tick_more;
   logic             table_full, tick_stall, tick_take;
   logic [32:0]      rem;
   logic [31:0]      delay_clamped;

   // Shared remaining-time unit: remaining = timeout - elapsed, signed.
   assign rem           = {1'b0, timeout_ff} - {1'b0, elapsed_ff};
   assign expired       = $signed({rem[32], rem}) <= $signed({2'b00, guard_ff});
   assign delay_clamped = (!rem[32] && (rem[31:0] != '0)) ? rem[31:0] : '0;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign tag_hit    = rd_data_ff.tag == req_ff.reply_tag;
   assign pos_more   = ({1'b0, pos_ff} + (CNT_W+1)'(1)) < {1'b0, count_ff};
   assign shift_more = ({1'b0, pos_ff} + (CNT_W+1)'(2)) < {1'b0, count_ff};
   assign tick_more  = (count_ff > CNT_W'(1)) &&
                       (({1'b0, n_ff} + (N_W+1)'(1)) < (N_W+1)'(MAX_RESULTS));
   assign table_full = count_ff >= CNT_W'(TABLE_DEPTH);
   // A held timeout result must go out before the next one replaces it.
   assign tick_stall = (fin_kind_ff == KIND_TIMEOUT) && !slot_free;
   assign tick_take  = (state_ff == ST_TICK_CALC) && expired && !tick_stall;

   assign req_ready   = state_ff == ST_IDLE;
   assign req_take    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_payload.command)
                  CMD_SEND:  state_in = ST_SEND;
                  CMD_REPLY: state_in = (count_ff == '0) ? ST_FIN_RD : ST_SRCH_RD;
                  CMD_TICK:  state_in = (count_ff == '0) ? ST_FIN_RD : ST_TICK_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEND:     state_in = ST_FIN_RD;
         ST_SRCH_RD:  state_in = ST_SRCH_EV;
         ST_SRCH_EV: begin
            if (tag_hit) begin
               state_in = (pos_ff != '0 && pos_more) ? ST_SHIFT_RD : ST_FIN_RD;
            end else begin
               state_in = pos_more ? ST_SRCH_RD : ST_FIN_RD;
            end
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = shift_more ? ST_SHIFT_RD : ST_FIN_RD;
         ST_TICK_RD:  state_in = ST_TICK_EV;
         ST_TICK_EV:  state_in = ST_TICK_CALC;
         ST_TICK_CALC: begin
            if (!expired) begin
               state_in = ST_FIN_RD;
            end else if (!tick_stall) begin
               state_in = tick_more ? ST_TICK_RD : ST_FIN_RD;
            end
         end
         ST_FIN_RD:   state_in = ST_FIN_EV;
         ST_FIN_EV:   state_in = ST_FIN_OUT;
         ST_FIN_OUT:  state_in = slot_free ? ST_IDLE : ST_FIN_OUT;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath controls.
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      base_in      = base_ff;
      fin_kind_in  = fin_kind_ff;
      fin_tag_in   = fin_tag_ff;
      fin_owner_in = fin_owner_ff;
      fin_upd_in   = fin_upd_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = rd_data_ff;
      elapsed_en   = 1'b0;
      emit         = 1'b0;
      emit_payload = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               pos_in = '0;
               n_in   = '0;
               case (req_payload.command)
                  CMD_REPLY: begin
                     fin_kind_in  = KIND_DISCARD;
                     fin_tag_in   = req_payload.reply_tag;
                     fin_owner_in = '0;
                     fin_upd_in   = 1'b0;
                  end
                  CMD_TICK: begin
                     fin_kind_in  = KIND_NONE;
                     fin_tag_in   = '0;
                     fin_owner_in = '0;
                     fin_upd_in   = count_ff != '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEND: begin
            fin_owner_in = req_ff.requester_id;
            if (table_full) begin
               fin_kind_in = KIND_FULL;
               fin_tag_in  = '0;
               fin_upd_in  = 1'b0;
            end else begin
               base_in           = base_ff + 16'd1;
               wr_en             = 1'b1;
               wr_addr           = ring_idx(head_ff, count_ff[IDX_W-1:0]);
               wr_data.tag       = base_ff + 16'd1;
               wr_data.sent_time = req_ff.now_ticks;
               wr_data.owner     = req_ff.requester_id;
               count_in          = count_ff + CNT_W'(1);
               fin_kind_in       = KIND_SENT;
               fin_tag_in        = base_ff + 16'd1;
               fin_upd_in        = count_ff == '0;
            end
         end
         ST_SRCH_RD: begin
            rd_en   = 1'b1;
            rd_addr = ring_idx(head_ff, pos_ff[IDX_W-1:0]);
         end
         ST_SRCH_EV: begin
            if (tag_hit) begin
               fin_kind_in  = KIND_MATCH;
               fin_owner_in = rd_data_ff.owner;
               fin_upd_in   = pos_ff == '0;
               if (pos_ff == '0) begin
                  head_in  = ring_idx(head_ff, IDX_W'(1));
                  count_in = count_ff - CNT_W'(1);
               end else if (!pos_more) begin
                  // Youngest entry matched: nothing to move up.
                  count_in = count_ff - CNT_W'(1);
               end
            end else if (pos_more) begin
               pos_in = pos_ff + CNT_W'(1);
            end
         end
         ST_SHIFT_RD: begin
            rd_en   = 1'b1;
            rd_addr = ring_idx(head_ff, pos_ff[IDX_W-1:0] + IDX_W'(1));
         end
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = ring_idx(head_ff, pos_ff[IDX_W-1:0]);
            wr_data = rd_data_ff;
            pos_in  = pos_ff + CNT_W'(1);
            if (!shift_more) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         ST_TICK_RD: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         ST_TICK_EV: begin
            elapsed_en = 1'b1;
         end
         ST_TICK_CALC: begin
            if (tick_take) begin
               if (fin_kind_ff == KIND_TIMEOUT) begin
                  emit               = 1'b1;
                  emit_payload.kind  = KIND_TIMEOUT;
                  emit_payload.tag   = fin_tag_ff;
                  emit_payload.owner = fin_owner_ff;
               end
               fin_kind_in  = KIND_TIMEOUT;
               fin_tag_in   = rd_data_ff.tag;
               fin_owner_in = rd_data_ff.owner;
               head_in      = ring_idx(head_ff, IDX_W'(1));
               count_in     = count_ff - CNT_W'(1);
               n_in         = n_ff + N_W'(1);
            end
         end
         ST_FIN_RD: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         ST_FIN_EV: begin
            elapsed_en = 1'b1;
         end
         ST_FIN_OUT: begin
            if (slot_free) begin
               emit                      = 1'b1;
               emit_payload.kind         = fin_kind_ff;
               emit_payload.tag          = fin_tag_ff;
               emit_payload.owner        = fin_owner_ff;
               emit_payload.timer_delay  = (count_ff == '0) ? '0 : delay_clamped;
               emit_payload.timer_update = fin_upd_ff;
               emit_payload.last         = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         n_ff         <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         guard_ff     <= GUARD_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         n_ff         <= n_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT: timeout_ff <= csr_wdata;
               CSR_GUARD:   guard_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_payload;
      end
      if (emit) begin
         rsp_payload_ff <= emit_payload;
      end
      if (elapsed_en) begin
         elapsed_ff <= req_ff.now_ticks - rd_data_ff.sent_time;
      end
      fin_kind_ff  <= fin_kind_in;
      fin_tag_ff   <= fin_tag_in;
      fin_owner_ff <= fin_owner_in;
      fin_upd_ff   <= fin_upd_in;
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   // Checks on the sequencer.
   `OOT_ASSERT_NEXT(a_last_returns_idle, clock, reset, emit && emit_payload.last, state_ff == ST_IDLE, "final result not followed by idle")
   `OOT_ASSERT_NEXT(a_full_send_keeps_count, clock, reset, state_ff == ST_SEND && table_full, count_ff == $past(count_ff) && base_ff == $past(base_ff), "send to full table changed the table")
   `OOT_ASSERT_NEXT(a_tick_removes_one, clock, reset, tick_take, count_ff == $past(count_ff) - CNT_W'(1), "timeout did not remove one entry")
   `OOT_ASSERT_NOW(a_count_bound, clock, reset, state_ff != ST_IDLE, count_ff <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")

endmodule
